/* rtl/core/step_sequencer_midi_gate_core_assert.svh */
`ifndef STEP_SEQUENCER_MIDI_GATE_CORE_ASSERT_SVH
`define STEP_SEQUENCER_MIDI_GATE_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define SSMG_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define SSMG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/ssmg_pkg.sv */
package ssmg_pkg;

   localparam int STEP_COUNT  = 8;
   localparam int STEP_W      = $clog2(STEP_COUNT);
   localparam int MAX_RESULTS = 2;
   localparam int FIFO_DEPTH  = 8;
   localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

   localparam logic [17:0] GATE_MAX      = 18'h3FFFF;
   localparam logic [7:0]  STATUS_OFF    = 8'h80;
   localparam logic [7:0]  STATUS_ON     = 8'h90;
   localparam logic [6:0]  NOTE_TOP      = 7'd127;
   localparam logic [6:0]  ROOT_RESET    = 7'd48;
   localparam logic [17:0] SPB_RESET     = 18'd24000;
   localparam logic [6:0]  VEL_RESET     = 7'd101;
   localparam logic [8:0]  GATE_RESET    = 9'd128;
   localparam logic [3:0]  PITCH_IDX_TOP = 4'd10;

   typedef enum logic [1:0] {
      CMD_TICK   = 2'd0,
      CMD_PLAY   = 2'd1,
      CMD_TOGGLE = 2'd2,
      CMD_WRITE  = 2'd3
   } cmd_type;

   typedef enum logic {
      CSR_ROOT_NOTE = 1'b0,
      CSR_SPB       = 1'b1
   } csr_index_type;

   typedef struct packed {
      cmd_type     command;
      logic        beat;
      logic [2:0]  step_index;
      logic [12:0] pitch;
      logic [6:0]  velocity;
      logic [8:0]  gate_fraction;
   } item_type;

   typedef struct packed {
      logic       midi_valid;
      logic [7:0] midi_status;
      logic [6:0] midi_note;
      logic [6:0] midi_velocity;
      logic       gate_open;
      logic [2:0] step_now;
      logic       is_playing;
      logic       last;
   } result_type;

   typedef struct packed {
      logic       two;
      result_type first;
      result_type second;
   } emit_type;

   function automatic logic [4:0] pent_offset(input logic [3:0] idx);
      logic [4:0] off;
      case (idx)
         4'd0:    off = 5'd0;
         4'd1:    off = 5'd2;
         4'd2:    off = 5'd4;
         4'd3:    off = 5'd7;
         4'd4:    off = 5'd9;
         4'd5:    off = 5'd12;
         4'd6:    off = 5'd14;
         4'd7:    off = 5'd16;
         4'd8:    off = 5'd19;
         4'd9:    off = 5'd21;
         default: off = 5'd24;
      endcase
      return off;
   endfunction

endpackage

/* rtl/core/ssmg_engine.sv */
module ssmg_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  ssmg_pkg::item_type item,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [17:0]       csr_wdata,
   output ssmg_pkg::emit_type emit
);
   import ssmg_pkg::*;

   logic [6:0]        root_ff;
   logic [17:0]       spb_ff;
   logic [12:0]       pitch_ff [STEP_COUNT];
   logic [6:0]        vel_ff   [STEP_COUNT];
   logic [8:0]        gate_ff  [STEP_COUNT];
   logic [STEP_COUNT-1:0] active_ff;

   logic [STEP_W-1:0] pos_ff, pos_in;
   logic              run_ff, run_in;
   logic              gflag_ff, gflag_in;
   logic [17:0]       gcount_ff, gcount_in;
   logic [17:0]       glen_ff, glen_in;
   logic [6:0]        prev_ff, prev_in;

   logic              idx_ok;
   logic [STEP_W-1:0] idx_sel;
   logic [STEP_W-1:0] pos_wrap;
   logic [STEP_W-1:0] trig_step;
   logic [16:0]       pitch_prod;
   logic [3:0]        pitch_idx;
   logic [7:0]        note_sum;
   logic [6:0]        trig_note;
   logic [26:0]       gate_prod;
   logic [18:0]       gate_shift;
   logic [17:0]       gate_len;
   logic              do_trig;
   logic              off_en;
   logic              on_en;
   result_type        off_msg;
   result_type        on_msg;
   result_type        idle_msg;

   assign idx_ok    = 32'(item.step_index) < STEP_COUNT;
   assign idx_sel   = STEP_W'(item.step_index);
   assign pos_wrap  = (pos_ff == STEP_W'(STEP_COUNT - 1)) ? '0 : pos_ff + STEP_W'(1);
   assign trig_step = (item.command == CMD_TICK) ? pos_wrap : '0;

   assign pitch_prod = 17'(pitch_ff[trig_step]) * 17'd10;
   assign pitch_idx  = (pitch_prod[16:12] > 5'(PITCH_IDX_TOP)) ? PITCH_IDX_TOP
                                                             : pitch_prod[15:12];
   assign note_sum   = 8'(root_ff) + 8'(pent_offset(pitch_idx));
   assign trig_note  = (note_sum > 8'(NOTE_TOP)) ? NOTE_TOP : note_sum[6:0];

   assign gate_prod  = 27'(spb_ff) * 27'(gate_ff[trig_step]);
   assign gate_shift = gate_prod[26:8];
   assign gate_len   = (gate_shift > 19'(GATE_MAX)) ? GATE_MAX : gate_shift[17:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff <= ROOT_RESET;
         spb_ff  <= SPB_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_ROOT_NOTE: root_ff <= csr_wdata[6:0];
            CSR_SPB:       spb_ff  <= csr_wdata;
            default:       root_ff <= root_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STEP_COUNT; i++) begin
            pitch_ff[i] <= 13'((i * 4096) / (STEP_COUNT - 1));
            vel_ff[i]   <= VEL_RESET;
            gate_ff[i]  <= GATE_RESET;
         end
         active_ff <= '1;
      end else if (item_valid && idx_ok) begin
         if (item.command == CMD_TOGGLE) begin
            active_ff[idx_sel] <= ~active_ff[idx_sel];
         end else if (item.command == CMD_WRITE) begin
            pitch_ff[idx_sel] <= item.pitch;
            vel_ff[idx_sel]   <= item.velocity;
            gate_ff[idx_sel]  <= item.gate_fraction;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         run_ff    <= 1'b0;
         gflag_ff  <= 1'b0;
         gcount_ff <= '0;
         glen_ff   <= '0;
         prev_ff   <= '0;
      end else begin
         pos_ff    <= pos_in;
         run_ff    <= run_in;
         gflag_ff  <= gflag_in;
         gcount_ff <= gcount_in;
         glen_ff   <= glen_in;
         prev_ff   <= prev_in;
      end
   end

   always_comb begin
      pos_in    = pos_ff;
      run_in    = run_ff;
      gflag_in  = gflag_ff;
      gcount_in = gcount_ff;
      glen_in   = glen_ff;
      prev_in   = prev_ff;
      do_trig   = 1'b0;
      off_en    = 1'b0;
      on_en     = 1'b0;

      if (item_valid) begin
         case (item.command)
            CMD_TICK: begin
               if (run_ff && item.beat) begin
                  pos_in  = pos_wrap;
                  do_trig = 1'b1;
               end
            end
            CMD_PLAY: begin
               run_in = ~run_ff;
               if (!run_ff) begin
                  pos_in  = '0;
                  do_trig = 1'b1;
               end else if (prev_ff != '0) begin
                  off_en  = 1'b1;
                  prev_in = '0;
               end
            end
            default: begin
               pos_in = pos_ff;
            end
         endcase
      end

      if (do_trig && active_ff[trig_step]) begin
         glen_in   = gate_len;
         gcount_in = '0;
         gflag_in  = 1'b1;
         off_en    = (prev_ff != '0);
         on_en     = 1'b1;
         prev_in   = trig_note;
      end

      if (item_valid && item.command == CMD_TICK && gflag_in) begin
         if (gcount_in != GATE_MAX) begin
            gcount_in = gcount_in + 18'd1;
         end
         if (gcount_in >= glen_in) begin
            gflag_in = 1'b0;
         end
      end

      idle_msg = '0;
      idle_msg.gate_open  = gflag_in;
      idle_msg.step_now   = 3'(pos_in);
      idle_msg.is_playing = run_in;

      off_msg = idle_msg;
      off_msg.midi_valid  = 1'b1;
      off_msg.midi_status = STATUS_OFF;
      off_msg.midi_note   = prev_ff;

      on_msg = idle_msg;
      on_msg.midi_valid    = 1'b1;
      on_msg.midi_status   = STATUS_ON;
      on_msg.midi_note     = trig_note;
      on_msg.midi_velocity = vel_ff[trig_step];
      on_msg.last          = 1'b1;

      emit.two    = off_en && on_en;
      emit.second = on_msg;
      if (off_en) begin
         emit.first = off_msg;
      end else if (on_en) begin
         emit.first = on_msg;
      end else begin
         emit.first = idle_msg;
      end
      emit.first.last = ~emit.two;
   end

endmodule

/* rtl/core/step_sequencer_midi_gate_core.sv */
// Channel  Dir  Ports                        Contents
// req      in   req_tvalid/tready/tdata/tuser  one command item
// rsp      out  rsp_tvalid/tready/tdata/tuser/tlast  one or two result items per command
// csr      in   csr_we/csr_index/csr_wdata     root note and samples per beat
//
// An accepted item is held in the input register and then decoded by the engine,
// which writes its one or two results into an eight-entry result queue.
// A new item is taken every cycle as long as the queue has room for the worst case of
// the in-register item plus the new one; a result leaves each cycle rsp_tready is high.
// Reset is synchronous, holds req_tready low and loads the default pattern and registers.
// A stalled result side fills the queue and then drops req_tready.
module step_sequencer_midi_gate_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // beat, step_index, pitch, velocity, gate_fraction
   input  logic [1:0]  req_tuser,  // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // midi_status, midi_note, midi_velocity, gate_open,
                                   // step_now, is_playing
   output logic        rsp_tuser,  // midi_valid
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [17:0] csr_wdata
);
   import ssmg_pkg::*;

   `include "step_sequencer_midi_gate_core_assert.svh"

   logic                 in_valid_ff, in_valid_in;
   item_type             in_ff, in_in;
   emit_type             emit;
   result_type           fifo_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   head_ff, head_in;
   logic [FIFO_AW-1:0]   tail_ff, tail_in;
   logic [FIFO_AW:0]     count_ff, count_in;
   logic [FIFO_AW+1:0]   need;
   logic                 req_fire;
   logic                 rsp_fire;
   logic [FIFO_AW:0]     push_n;
   result_type           head_item;

   assign need       = (FIFO_AW + 2)'(count_ff)
                     + (in_valid_ff ? (FIFO_AW + 2)'(2 * MAX_RESULTS)
                                    : (FIFO_AW + 2)'(MAX_RESULTS));
   assign req_tready = !reset && (need <= (FIFO_AW + 2)'(FIFO_DEPTH));
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = count_ff != '0;
   assign rsp_fire   = rsp_tvalid && rsp_tready;

   assign in_valid_in = req_fire;
   always_comb begin
      in_in.command       = cmd_type'(req_tuser);
      in_in.beat          = req_tdata[0];
      in_in.step_index    = req_tdata[3:1];
      in_in.pitch         = req_tdata[16:4];
      in_in.velocity      = req_tdata[23:17];
      in_in.gate_fraction = req_tdata[32:24];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_ff <= in_in;
      end
   end

   ssmg_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .item_valid (in_valid_ff),
      .item       (in_ff),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .emit       (emit)
   );

   always_comb begin
      push_n   = in_valid_ff ? (emit.two ? (FIFO_AW + 1)'(2) : (FIFO_AW + 1)'(1)) : '0;
      tail_in  = tail_ff + FIFO_AW'(push_n);
      head_in  = rsp_fire ? head_ff + FIFO_AW'(1) : head_ff;
      count_in = count_ff + push_n - (rsp_fire ? (FIFO_AW + 1)'(1) : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid_ff) begin
         fifo_ff[tail_ff] <= emit.first;
         if (emit.two) begin
            fifo_ff[tail_ff + FIFO_AW'(1)] <= emit.second;
         end
      end
   end

   assign head_item = fifo_ff[head_ff];
   assign rsp_tuser = head_item.midi_valid;
   assign rsp_tlast = head_item.last;
   assign rsp_tdata = {5'b0, head_item.is_playing, head_item.step_now, head_item.gate_open,
                       head_item.midi_velocity, head_item.midi_note, head_item.midi_status};

   `SSMG_ASSERT_IMP(a_queue_bound, clock, reset, 1'b1,
      count_ff <= (FIFO_AW + 1)'(FIFO_DEPTH), "result queue overflow")
   `SSMG_ASSERT_IMP(a_pair_last, clock, reset, in_valid_ff && emit.two,
      !emit.first.last && emit.second.last && emit.first.midi_status == STATUS_OFF,
      "note pair out of order")
   `SSMG_ASSERT_NEXT(a_stage_load, clock, reset, req_fire, in_valid_ff,
      "accepted item not staged")
   `SSMG_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_tvalid && !rsp_tready,
      count_ff >= $past(count_ff), "queue lost an item while stalled")

endmodule

/* tb/sv/step_sequencer_midi_gate_core_tb.sv */
`timescale 1ns / 100ps

module step_sequencer_midi_gate_core_tb;
   import ssmg_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int LONG_HOLD = 400;
   localparam logic [54:0] PENT_SCALE = {5'd24, 5'd21, 5'd19, 5'd16, 5'd14, 5'd12,
                                         5'd9, 5'd7, 5'd4, 5'd2, 5'd0};

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [39:0]   req_tdata = '0;
   logic [1:0]    req_tuser = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [31:0]   rsp_tdata;
   logic          rsp_tuser;
   logic          rsp_tlast;
   logic          csr_we = 1'b0;
   csr_index_type csr_index = CSR_ROOT_NOTE;
   logic [17:0]   csr_wdata = '0;

   // Sequencer state as the block should hold it.
   logic [12:0] pat_pitch [STEP_COUNT];
   logic [6:0]  pat_vel [STEP_COUNT];
   logic [8:0]  pat_gate [STEP_COUNT];
   logic        pat_on [STEP_COUNT];
   logic [2:0]  seq_pos;
   logic        seq_run;
   logic        gate_on;
   logic [17:0] gate_cnt;
   logic [17:0] gate_len;
   logic [6:0]  sounding;
   logic [6:0]  root_cfg;
   logic [17:0] spb_cfg;

   item_type   cmd_backlog [$];
   result_type due_results [$];
   result_type midi_msgs [$];
   item_type   offered;
   logic       gen_running = 1'b0;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_token = 0;
   int holds_done = 0;
   int hold_left = 0;
   int mismatches = 0;
   int accepted_items = 0;
   int checked_results = 0;
   int note_ons = 0;
   int note_offs = 0;
   int idle_cycles = 0;

   step_sequencer_midi_gate_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [6:0] pitch_note(input logic [12:0] pitch);
      logic [16:0] scaled;
      logic [4:0]  slot;
      logic [7:0]  sum;
      scaled = {4'd0, pitch} * 17'd10;
      slot = scaled[16:12];
      if (slot > 5'd10)
         slot = 5'd10;
      sum = {1'b0, root_cfg} + {3'd0, PENT_SCALE[slot * 5 +: 5]};
      return (sum > 8'd127) ? NOTE_TOP : sum[6:0];
   endfunction

   task automatic emit_midi(input logic [7:0] status, input logic [6:0] note,
                            input logic [6:0] vel);
      result_type r;
      r = '0;
      r.midi_valid = 1'b1;
      r.midi_status = status;
      r.midi_note = note;
      r.midi_velocity = vel;
      midi_msgs.push_back(r);
   endtask

   task automatic strike_step(input logic [2:0] s);
      logic [35:0] prod;
      logic [6:0]  note;
      if (pat_on[s]) begin
         prod = {18'd0, spb_cfg} * {27'd0, pat_gate[s]};
         gate_len = (prod[35:8] > {10'd0, GATE_MAX}) ? GATE_MAX : prod[25:8];
         gate_cnt = '0;
         gate_on = 1'b1;
         note = pitch_note(pat_pitch[s]);
         if (sounding != 7'd0)
            emit_midi(STATUS_OFF, sounding, 7'd0);
         emit_midi(STATUS_ON, note, pat_vel[s]);
         sounding = note;
      end
   endtask

   task automatic advance_sequencer(input item_type it);
      result_type r;
      midi_msgs.delete();
      case (it.command)
         CMD_TICK: begin
            if (seq_run && it.beat) begin
               seq_pos = seq_pos + 3'd1;
               strike_step(seq_pos);
            end
            if (gate_on) begin
               if (gate_cnt != GATE_MAX)
                  gate_cnt = gate_cnt + 18'd1;
               if (gate_cnt >= gate_len)
                  gate_on = 1'b0;
            end
         end
         CMD_PLAY: begin
            seq_run = !seq_run;
            if (seq_run) begin
               seq_pos = '0;
               strike_step(3'd0);
            end else if (sounding != 7'd0) begin
               emit_midi(STATUS_OFF, sounding, 7'd0);
               sounding = '0;
            end
         end
         CMD_TOGGLE: begin
            pat_on[it.step_index] = !pat_on[it.step_index];
         end
         default: begin
            pat_pitch[it.step_index] = it.pitch;
            pat_vel[it.step_index] = it.velocity;
            pat_gate[it.step_index] = it.gate_fraction;
         end
      endcase
      if (midi_msgs.size() == 0) begin
         r = '0;
         midi_msgs.push_back(r);
      end
      foreach (midi_msgs[k]) begin
         r = midi_msgs[k];
         r.gate_open = gate_on;
         r.step_now = seq_pos;
         r.is_playing = seq_run;
         r.last = (k == midi_msgs.size() - 1);
         due_results.push_back(r);
      end
   endtask

   task automatic flag_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch in %s at result %0d: expected %0d, got %0d",
                     name, checked_results, want, got);
      end
   endtask

   always @(posedge clock) begin : driver
      item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            advance_sequencer(offered);
            accepted_items++;
         end
         if (!req_tvalid || req_tready) begin
            if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = cmd_backlog.pop_front();
               offered <= nxt;
               req_tvalid <= 1'b1;
               req_tuser <= nxt.command;
               req_tdata <= {7'd0, nxt.gate_fraction, nxt.velocity, nxt.pitch,
                             nxt.step_index, nxt.beat};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      result_type got;
      result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.midi_valid = rsp_tuser;
            got.midi_status = rsp_tdata[7:0];
            got.midi_note = rsp_tdata[14:8];
            got.midi_velocity = rsp_tdata[21:15];
            got.gate_open = rsp_tdata[22];
            got.step_now = rsp_tdata[25:23];
            got.is_playing = rsp_tdata[26];
            got.last = rsp_tlast;
            if (due_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result with tdata %h", rsp_tdata);
            end else begin
               want = due_results.pop_front();
               flag_field("midi_valid", 32'(want.midi_valid), 32'(got.midi_valid));
               flag_field("midi_status", 32'(want.midi_status), 32'(got.midi_status));
               flag_field("midi_note", 32'(want.midi_note), 32'(got.midi_note));
               flag_field("midi_velocity", 32'(want.midi_velocity),
                          32'(got.midi_velocity));
               flag_field("gate_open", 32'(want.gate_open), 32'(got.gate_open));
               flag_field("step_now", 32'(want.step_now), 32'(got.step_now));
               flag_field("is_playing", 32'(want.is_playing), 32'(got.is_playing));
               flag_field("last", 32'(want.last), 32'(got.last));
            end
            if (got.midi_valid === 1'b1 && got.midi_status === STATUS_ON)
               note_ons++;
            if (got.midi_valid === 1'b1 && got.midi_status === STATUS_OFF)
               note_offs++;
            checked_results++;
         end
         if (hold_token != holds_done) begin
            holds_done <= hold_token;
            hold_left <= LONG_HOLD;
            rsp_tready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("no item moved for %0d cycles, %0d results still due",
                  WATCHDOG_LIMIT, due_results.size());
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic queue_cmd(input cmd_type cmd, input logic beat, input logic [2:0] idx,
                            input logic [12:0] pitch, input logic [6:0] vel,
                            input logic [8:0] frac);
      item_type it;
      it.command = cmd;
      it.beat = beat;
      it.step_index = idx;
      it.pitch = pitch;
      it.velocity = vel;
      it.gate_fraction = frac;
      if (cmd == CMD_PLAY)
         gen_running = !gen_running;
      cmd_backlog.push_back(it);
   endtask

   task automatic queue_random(input int count);
      int          roll;
      cmd_type     cmd;
      logic [12:0] pitch;
      logic [8:0]  frac;
      logic        beat;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         beat = 1'($urandom_range(1));
         if (gen_running) begin
            cmd = (roll < 3) ? CMD_PLAY : (roll < 10) ? CMD_TOGGLE :
                  (roll < 18) ? CMD_WRITE : CMD_TICK;
            if (cmd == CMD_TICK)
               beat = ($urandom_range(3) == 0);
         end else begin
            cmd = (roll < 25) ? CMD_PLAY : (roll < 35) ? CMD_TOGGLE :
                  (roll < 50) ? CMD_WRITE : CMD_TICK;
         end
         pitch = $urandom_range(1) ? 13'($urandom_range(4096)) : 13'($urandom_range(8191));
         frac = ($urandom_range(3) != 0) ? 9'($urandom_range(256)) : 9'($urandom_range(511));
         queue_cmd(cmd, beat, 3'($urandom_range(7)), pitch, 7'($urandom_range(127)), frac);
      end
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [17:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_ROOT_NOTE)
         root_cfg = value[6:0];
      else
         spb_cfg = value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      while (cmd_backlog.size() != 0 || req_tvalid || due_results.size() != 0)
         @(negedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic start_phase(input logic [17:0] root, input logic [17:0] spb,
                              input int send_idle, input int recv_stall);
      drain();
      write_csr(CSR_ROOT_NOTE, root);
      write_csr(CSR_SPB, spb);
      send_idle_pct <= send_idle;
      recv_stall_pct <= recv_stall;
   endtask

   initial begin : stimulus
      for (int i = 0; i < STEP_COUNT; i++) begin
         pat_pitch[i] = 13'((i * 4096) / (STEP_COUNT - 1));
         pat_vel[i] = VEL_RESET;
         pat_gate[i] = GATE_RESET;
         pat_on[i] = 1'b1;
      end
      seq_pos = '0;
      seq_run = 1'b0;
      gate_on = 1'b0;
      gate_cnt = '0;
      gate_len = '0;
      sounding = '0;
      root_cfg = ROOT_RESET;
      spb_cfg = SPB_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Pattern and registers as they come out of reset.
      queue_cmd(CMD_TICK, 1'b1, 3'd0, 13'd0, 7'd0, 9'd0);
      queue_cmd(CMD_PLAY, 1'b0, 3'd0, 13'd0, 7'd0, 9'd0);
      queue_cmd(CMD_TICK, 1'b1, 3'd7, 13'd8191, 7'd127, 9'd511);
      queue_cmd(CMD_TOGGLE, 1'b0, 3'd2, 13'd0, 7'd0, 9'd0);
      queue_cmd(CMD_TICK, 1'b1, 3'd0, 13'd0, 7'd0, 9'd0);
      queue_cmd(CMD_WRITE, 1'b0, 3'd3, 13'd4096, 7'd127, 9'd0);
      queue_cmd(CMD_TICK, 1'b1, 3'd0, 13'd0, 7'd0, 9'd0);
      queue_cmd(CMD_TICK, 1'b0, 3'd0, 13'd0, 7'd0, 9'd0);
      queue_cmd(CMD_WRITE, 1'b1, 3'd4, 13'd8191, 7'd0, 9'd511);
      queue_cmd(CMD_TICK, 1'b1, 3'd5, 13'd1, 7'd1, 9'd1);
      queue_cmd(CMD_TICK, 1'b0, 3'd0, 13'd0, 7'd0, 9'd0);
      queue_cmd(CMD_PLAY, 1'b1, 3'd7, 13'd8191, 7'd127, 9'd511);
      queue_cmd(CMD_TICK, 1'b0, 3'd0, 13'd0, 7'd0, 9'd0);
      queue_cmd(CMD_TICK, 1'b1, 3'd0, 13'd0, 7'd0, 9'd0);
      queue_cmd(CMD_TOGGLE, 1'b1, 3'd2, 13'd8191, 7'd127, 9'd511);
      queue_cmd(CMD_TOGGLE, 1'b0, 3'd7, 13'd0, 7'd0, 9'd0);
      queue_cmd(CMD_TOGGLE, 1'b0, 3'd7, 13'd0, 7'd0, 9'd0);
      queue_cmd(CMD_WRITE, 1'b0, 3'd0, 13'd0, 7'd127, 9'd256);
      queue_cmd(CMD_WRITE, 1'b0, 3'd7, 13'd4095, 7'd1, 9'd1);
      queue_cmd(CMD_PLAY, 1'b0, 3'd0, 13'd0, 7'd0, 9'd0);
      queue_cmd(CMD_PLAY, 1'b0, 3'd0, 13'd0, 7'd0, 9'd0);

      // Root zero makes note 0, which must never be followed by a note-off.
      start_phase(18'd0, 18'd1, 0, 0);
      hold_token <= hold_token + 1;
      queue_cmd(CMD_WRITE, 1'b0, 3'd0, 13'd0, 7'd5, 9'd256);
      queue_cmd(CMD_WRITE, 1'b0, 3'd1, 13'd409, 7'd9, 9'd0);
      if (gen_running)
         queue_cmd(CMD_PLAY, 1'b0, 3'd0, 13'd0, 7'd0, 9'd0);
      queue_cmd(CMD_PLAY, 1'b0, 3'd0, 13'd0, 7'd0, 9'd0);
      queue_cmd(CMD_TICK, 1'b1, 3'd0, 13'd0, 7'd0, 9'd0);
      queue_cmd(CMD_TICK, 1'b0, 3'd0, 13'd0, 7'd0, 9'd0);
      queue_cmd(CMD_PLAY, 1'b0, 3'd0, 13'd0, 7'd0, 9'd0);
      queue_random(280);

      start_phase(18'd103, 18'd262143, 58, 0);
      queue_random(250);
      start_phase(18'd127, 18'd0, 0, 58);
      queue_random(250);
      start_phase(18'd60, 18'd7, 30, 30);
      queue_random(300);
      start_phase(18'($urandom_range(103)), 18'($urandom_range(64, 1)), 0, 0);
      queue_random(300);
      start_phase(18'($urandom_range(103)), 18'($urandom_range(262143, 1)), 30, 30);
      queue_random(200);
      start_phase(18'd48, 18'd24, 58, 58);
      queue_random(320);
      drain();

      $display("%0d items sent over eight register settings, %0d results checked",
               accepted_items, checked_results);
      $display("%0d note-ons and %0d note-offs seen, %0d mismatches",
               note_ons, note_offs, mismatches);
      if (mismatches == 0 && due_results.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/ssmg_pkg.sv
rtl/core/ssmg_engine.sv
rtl/core/step_sequencer_midi_gate_core.sv
tb/sv/step_sequencer_midi_gate_core_tb.sv
